[rtl/vtp_pkg.sv]
package vtp_pkg;
  localparam int FracBitsDefault = 16;
  localparam int NumRegs = 8;
  localparam int RegWidth = 64;
  localparam int IdxWidth = 3;
  localparam int DataWidth = 32;
  localparam int QuoWidth = 49;  // 32 + 16 + 1, default frac
  localparam logic [DataWidth-1:0] SatMax = 32'h7fff_ffff;
  localparam logic [DataWidth-1:0] SatMin = 32'h8000_0000;

  typedef struct packed {
    logic [DataWidth-1:0] x;
    logic [DataWidth-1:0] y;
    logic [DataWidth-1:0] z;
    logic                 divided;
  } vtx_out_t;
endpackage

[rtl/vtp_dot.sv]
module vtp_dot #(
  parameter int FRAC_BITS = vtp_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] m0,
  input  logic signed [31:0] m1,
  input  logic signed [31:0] m2,
  input  logic signed [31:0] m3,
  input  logic signed [31:0] v0,
  input  logic signed [31:0] v1,
  input  logic signed [31:0] v2,
  input  logic signed [31:0] v3,
  output logic signed [31:0] dot
);
  localparam int SumW = 66;
  logic signed [63:0] p0, p1, p2, p3;
  logic signed [SumW-1:0] s01, s23;
  logic signed [SumW-1:0] tot;
  logic signed [SumW-1:0] shr;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= m0 * v0;
      p1 <= m1 * v1;
      p2 <= m2 * v2;
      p3 <= m3 * v3;
      s01 <= SumW'(p0) + SumW'(p1);
      s23 <= SumW'(p2) + SumW'(p3);
      if (shr > SumW'(signed'(vtp_pkg::SatMax))) begin
        dot <= signed'(vtp_pkg::SatMax);
      end else if (shr < -SumW'(signed'(vtp_pkg::SatMax)) - SumW'(1)) begin
        dot <= signed'(vtp_pkg::SatMin);
      end else begin
        dot <= shr[31:0];
      end
    end
  end

  assign tot = s01 + s23;
  assign shr = tot >>> FRAC_BITS;
endmodule

[rtl/vtp_div.sv]
module vtp_div #(
  parameter int FRAC_BITS = vtp_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               en,
  input  logic               go_in,
  input  logic signed [31:0] num_in,
  input  logic signed [31:0] den_in,
  output logic signed [31:0] res
);
  // restoring divider, one quotient bit per stage, magnitudes
  localparam int NW = 32 + FRAC_BITS;
  localparam int QW = NW;
  logic [NW-1:0] num_s [QW+1];
  logic [32:0]   rem_s [QW+1];
  logic [31:0]   den_s [QW+1];
  logic [QW-1:0] quo_s [QW+1];
  logic          neg_s [QW+1];
  logic          go_s  [QW+1];
  logic signed [31:0] raw_s [QW+1];
  logic [QW:0]   qs;
  logic [QW:0]   lim;

  always_comb begin
    num_s[0] = {(num_in[31] ? 32'(-num_in) : num_in), {FRAC_BITS{1'b0}}};
    den_s[0] = den_in[31] ? 32'(-den_in) : den_in;
    rem_s[0] = '0;
    quo_s[0] = '0;
    neg_s[0] = num_in[31] ^ den_in[31];
    go_s[0]  = go_in;
    raw_s[0] = num_in;
  end

  for (genvar i = 0; i < QW; i++) begin : g_st
    logic [32:0] tr;
    logic [32:0] df;
    assign tr = {rem_s[i][31:0], num_s[i][NW-1-i]};
    assign df = tr - {1'b0, den_s[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        num_s[i+1] <= num_s[i];
        den_s[i+1] <= den_s[i];
        neg_s[i+1] <= neg_s[i];
        go_s[i+1]  <= go_s[i];
        raw_s[i+1] <= raw_s[i];
        if (!df[32]) begin
          rem_s[i+1] <= df;
          quo_s[i+1] <= {quo_s[i][QW-2:0], 1'b1};
        end else begin
          rem_s[i+1] <= tr;
          quo_s[i+1] <= {quo_s[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign qs = neg_s[QW] ? -{1'b0, quo_s[QW]} : {1'b0, quo_s[QW]};
  assign lim = (QW+1)'(33'h0_8000_0000);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!go_s[QW]) res <= raw_s[QW];
      else if (!neg_s[QW] && quo_s[QW] > QW'(vtp_pkg::SatMax)) res <= vtp_pkg::SatMax;
      else if (neg_s[QW] && {1'b0, quo_s[QW]} > lim) res <= vtp_pkg::SatMin;
      else res <= qs[31:0];
    end
  end
endmodule

[rtl/vertex_transform_perspective_top.sv]
// Registers: products, pair sums, saturated dot, divider stages, divider result.
// Throughput: one item per cycle while the skid is empty; divider is bit-per-stage.
// A stall freezes the whole pipe; a one-entry skid keeps tready registered.
// Reset (rst, synchronous) loads the identity matrix and clears all valid bits.
module vertex_transform_perspective_top #(
  parameter int FRAC_BITS = vtp_pkg::FracBitsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // in_x, in_y, in_z, in_w
  input  logic         s_tuser,  // divide_request
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,  // out_x, out_y, out_z
  output logic         m_tuser   // divided
);
  localparam int Depth = 4 + 32 + FRAC_BITS;
  logic [63:0] regs [vtp_pkg::NumRegs];
  logic [Depth-1:0] vld;
  logic en;
  logic [2:0] req_d;
  logic signed [31:0] dx, dy, dz, dw;
  logic [Depth-4:0] dv_d;
  logic signed [31:0] qx, qy, qz;
  logic go;
  logic sk_v;
  vtp_pkg::vtx_out_t sk, cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= 64'(1) << FRAC_BITS;
      regs[1] <= '0;
      regs[2] <= 64'(1) << (FRAC_BITS + 32);
      regs[3] <= '0;
      regs[4] <= '0;
      regs[5] <= 64'(1) << FRAC_BITS;
      regs[6] <= '0;
      regs[7] <= 64'(1) << (FRAC_BITS + 32);
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // pipe advances unless the skid holds an item
  assign en = !sk_v;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Depth-2:0], s_tvalid};
  end

  always_ff @(posedge clk) begin
    if (en) req_d <= {req_d[1:0], s_tuser};
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    logic signed [31:0] d;
    vtp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
      .clk(clk), .en(en),
      .m0(regs[2*r][31:0]), .m1(regs[2*r][63:32]),
      .m2(regs[2*r+1][31:0]), .m3(regs[2*r+1][63:32]),
      .v0(s_tdata[31:0]), .v1(s_tdata[63:32]),
      .v2(s_tdata[95:64]), .v3(s_tdata[127:96]),
      .dot(d)
    );
  end
  assign dx = g_row[0].d;
  assign dy = g_row[1].d;
  assign dz = g_row[2].d;
  assign dw = g_row[3].d;
  assign go = req_d[2] && (dw != 32'sd0);

  vtp_div #(.FRAC_BITS(FRAC_BITS)) u_dx (.clk(clk), .en(en), .go_in(go),
    .num_in(dx), .den_in(dw), .res(qx));
  vtp_div #(.FRAC_BITS(FRAC_BITS)) u_dy (.clk(clk), .en(en), .go_in(go),
    .num_in(dy), .den_in(dw), .res(qy));
  vtp_div #(.FRAC_BITS(FRAC_BITS)) u_dz (.clk(clk), .en(en), .go_in(go),
    .num_in(dz), .den_in(dw), .res(qz));

  always_ff @(posedge clk) begin
    if (en) dv_d <= {dv_d[Depth-5:0], go};
  end

  assign cur.x = qx;
  assign cur.y = qy;
  assign cur.z = qz;
  assign cur.divided = dv_d[Depth-4];

  always_ff @(posedge clk) begin
    if (rst) sk_v <= 1'b0;
    else if (sk_v && m_tready) sk_v <= 1'b0;
    else if (!sk_v && vld[Depth-1] && !m_tready) sk_v <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (!sk_v) sk <= cur;
  end

  assign m_tvalid = sk_v || vld[Depth-1];
  assign m_tdata  = sk_v ? {sk.z, sk.y, sk.x} : {cur.z, cur.y, cur.x};
  assign m_tuser  = sk_v ? sk.divided : cur.divided;

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    sk_v && !m_tready |=> sk_v) else $error("skid lost item");
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    sk_v |-> !s_tready) else $error("accepted while skid full");
  a_div_only_req: assert property (@(posedge clk) disable iff (rst)
    en && go |-> req_d[2]) else $error("divide without request");
endmodule

[dv/vtp_checker.sv]
`timescale 1ns / 100ps

module vtp_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [95:0]  m_tdata,
  input  logic         m_tuser,
  output int           fail_count,
  output int           pending,
  output int           seen_count,
  output int           div_count
);
  localparam int Frac = vtp_pkg::FracBitsDefault;

  logic [vtp_pkg::RegWidth-1:0] matrix [vtp_pkg::NumRegs];
  vtp_pkg::vtx_out_t expected_q[$];

  function automatic logic signed [63:0] sat(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return v[63:0];
  endfunction

  function automatic logic signed [31:0] coef(int r, int c);
    logic [63:0] reg_val;
    reg_val = matrix[r * 2 + c / 2];
    return (c % 2) ? reg_val[63:32] : reg_val[31:0];
  endfunction

  // exact floor of the full-width sum, then saturate
  function automatic logic signed [63:0] row_sum(int r, logic [127:0] v);
    logic signed [127:0] acc;
    logic signed [31:0] e;
    acc = 0;
    for (int c = 0; c < 4; c++) begin
      e = v[32 * c +: 32];
      acc += 128'(coef(r, c)) * 128'(e);
    end
    return sat(acc >>> Frac);
  endfunction

  function automatic logic signed [63:0] quotient(logic signed [63:0] n,
                                                  logic signed [63:0] d);
    logic signed [127:0] num;
    num = 128'(n) <<< Frac;
    return sat(num / 128'(d));
  endfunction

  function automatic vtp_pkg::vtx_out_t transform(logic [127:0] v, logic want_div);
    vtp_pkg::vtx_out_t r;
    logic signed [63:0] x, y, z, w;
    x = row_sum(0, v);
    y = row_sum(1, v);
    z = row_sum(2, v);
    w = row_sum(3, v);
    r.divided = want_div && (w != 0);
    if (r.divided) begin
      x = quotient(x, w);
      y = quotient(y, w);
      z = quotient(z, w);
    end
    r.x = x[31:0];
    r.y = y[31:0];
    r.z = z[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    vtp_pkg::vtx_out_t exp_v;
    if (rst) begin
      matrix[0] <= 64'h1 << Frac;
      matrix[1] <= '0;
      matrix[2] <= 64'h1 << (Frac + 32);
      matrix[3] <= '0;
      matrix[4] <= '0;
      matrix[5] <= 64'h1 << Frac;
      matrix[6] <= '0;
      matrix[7] <= 64'h1 << (Frac + 32);
      expected_q.delete();
      fail_count <= 0;
      seen_count <= 0;
      div_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) matrix[cfg_index] <= cfg_data;
      if (s_tvalid && s_tready) expected_q.push_back(transform(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        seen_count <= seen_count + 1;
        if (m_tuser) div_count <= div_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h/%b", $time, m_tdata, m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_v = expected_q.pop_front();
          if (m_tdata != {exp_v.z, exp_v.y, exp_v.x} || m_tuser != exp_v.divided) begin
            $display("%0t: mismatch exp x=%h y=%h z=%h div=%b act x=%h y=%h z=%h div=%b",
                     $time, exp_v.x, exp_v.y, exp_v.z, exp_v.divided,
                     m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  localparam int Latency = 52;
  localparam longint CycleLimit = 1000000;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         s_tuser = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [95:0]  m_tdata;
  logic         m_tuser;
  int           fail_count, pending, seen_count, div_count;
  int           send_idle = 0, recv_stall = 0;
  longint       cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  vertex_transform_perspective_top dut (.*);

  vtp_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return '0;
      default: return 32'($signed($urandom_range(4 * 65536)) - 2 * 65536);
    endcase
  endfunction

  task automatic send_vertex(logic [127:0] v, logic want_div);
    cfg_we <= 0;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= v;
    s_tuser <= want_div;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  initial begin
    logic [127:0] v;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // identity, then edges
    send_vertex({32'h0001_0000, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000}, 1);
    send_vertex({32'h0000_0000, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000}, 1);
    send_vertex({32'h0002_0000, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000}, 0);
    send_vertex({32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 1);
    send_vertex({32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000}, 1);
    send_vertex({32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001}, 1);
    send_vertex({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 1);
    send_vertex('0, 1);
    drain();
    // extreme matrix: sums overflow
    for (int i = 0; i < vtp_pkg::NumRegs; i++) write_reg(3'(i), 64'h7fff_ffff_7fff_ffff);
    send_vertex({4{32'h7fff_ffff}}, 0);
    send_vertex({4{32'h8000_0000}}, 1);
    send_vertex({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 1);
    drain();
    for (int i = 0; i < vtp_pkg::NumRegs; i++) write_reg(3'(i), 64'h8000_0000_8000_0000);
    send_vertex({4{32'h7fff_ffff}}, 1);
    send_vertex({4{32'h8000_0000}}, 1);
    drain();
    for (int i = 0; i < vtp_pkg::NumRegs; i++) write_reg(3'(i), '0);
    send_vertex({4{32'h1234_5678}}, 1);
    drain();
    // small w row: quotient overflow
    write_reg(3'd0, 64'h7fff_ffff);
    write_reg(3'd7, 64'h1 << 32);
    send_vertex({32'h0001_0000, 32'h0, 32'h0, 32'h7fff_ffff}, 1);
    send_vertex({32'hffff_0000, 32'h0, 32'h0, 32'h7fff_ffff}, 1);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      for (int i = 0; i < vtp_pkg::NumRegs; i++) begin
        if (phase == 0) write_reg(3'(i), '1);
        else write_reg(3'(i), {rand_coef(), rand_coef()});
      end
      case (phase % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 58; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 58; end
        default: begin send_idle = 7; recv_stall = 7; end
      endcase
      for (int n = 0; n < 190; n++) begin
        v = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        send_vertex(v, $urandom_range(3) != 0);
      end
      send_idle = 0;
      recv_stall = 0;
      drain();
    end

    $display("Ran %0d vertices through identity, extreme and random matrices.", seen_count);
    $display("%0d results took the perspective divide.", div_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
